// ===== rtl/lps_pkg.sv =====
// ============================================================================
// LED pattern sequencer package
// Shared constants, the controller state type and the command and status
// structures that join the controller to the datapath.
// ============================================================================
package lps_pkg;

    // Default sizing of the event queue and the duration timer.
    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int DURATION_BITS_DEF = 16;

    // Fixed widths of the item and result fields.
    localparam int DUR_IN_W = 16;
    localparam int LEVEL_W  = 6;

    // Item function codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic rd_en;    // read the event at the head of the queue
        logic commit;   // update the state and load the result register
    } lps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_tick; // the latched item is a tick
    } lps_status_t;

endpackage

// ===== rtl/lps_ctrl.sv =====
// ============================================================================
// LED pattern sequencer controller
// Steps each accepted item through capture, event read (a tick only) and commit, and owns
// the valid flag of the result register.
// ============================================================================
module lps_ctrl
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  lps_status_t status,
    output lps_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   result_free;

    // The result register may be reloaded when it is empty or being taken.
    assign result_free = !result_valid_reg || !result_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (result_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        item_stall  = 1'b1;
        cmd.capture = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ST_READ:
            begin
                cmd.rd_en = status.item_tick;
            end
            ST_EXEC:
            begin
                cmd.commit = result_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // The result valid flag is set on commit and cleared when taken.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/lps_datapath.sv =====
// ============================================================================
// LED pattern sequencer datapath
// Holds the event queue memory, its indices and fill count, the duration
// timer, the LED level and the result register.
// ============================================================================
module lps_datapath
    import lps_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lps_cmd_t            cmd,
    output lps_status_t         status,
    input  logic                func,
    input  logic                led_state,
    input  logic [DUR_IN_W-1:0] duration,
    output logic                led_on,
    output logic                push_status,
    output logic [LEVEL_W-1:0]  queue_level,
    output logic                timer_busy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] DUR_MAX = (64'd1 << DURATION_BITS) - 64'd1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // Latched item.
    logic                     item_func_reg;
    logic                     item_state_reg;
    logic [DURATION_BITS-1:0] item_dur_reg;
    logic [DURATION_BITS-1:0] item_dur_next;

    // Event memory and its registered read port.
    logic [DURATION_BITS:0]   mem [QUEUE_DEPTH];
    logic [DURATION_BITS:0]   rd_data_reg;
    logic                     mem_we;

    // Queue and timer state.
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         rd_idx_next;
    logic [IDX_W-1:0]         wr_idx_reg;
    logic [IDX_W-1:0]         wr_idx_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [DURATION_BITS-1:0] time_reg;
    logic [DURATION_BITS-1:0] time_next;
    logic [DURATION_BITS-1:0] time_dec;
    logic                     led_reg;
    logic                     led_next;
    logic                     drop;

    // Result register.
    logic                     led_on_reg;
    logic                     push_status_reg;
    logic [LEVEL_W-1:0]       queue_level_reg;
    logic                     timer_busy_reg;

    logic [63:0]              dur_wide;
    logic [63:0]              dur_sat;
    logic [CNT_W+LEVEL_W-1:0] level_wide;

    // Durations wider than the timer saturate at its largest value.
    always_comb
    begin
        dur_wide      = {{(64 - DUR_IN_W){1'b0}}, duration};
        dur_sat       = (dur_wide > DUR_MAX) ? DUR_MAX : dur_wide;
        item_dur_next = dur_sat[DURATION_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_func_reg  <= func;
            item_state_reg <= led_state;
            item_dur_reg   <= item_dur_next;
        end
    end

    assign status.item_tick = (item_func_reg == FUNC_TICK);

    // Event memory: written on an accepted push, read ahead of a tick.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= {item_state_reg, item_dur_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // The timer counts down by one on a tick while it is running.
    assign time_dec = (time_reg != '0) ? time_reg - 1'b1 : time_reg;

    // Push and tick updates of the queue, timer and LED.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        led_next    = led_reg;
        drop        = 1'b0;
        mem_we      = 1'b0;
        if (cmd.commit)
        begin
            if (item_func_reg == FUNC_PUSH)
            begin
                if (count_reg >= FULL_CNT)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    mem_we      = 1'b1;
                    wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                time_next = time_dec;
                if (time_dec == '0)
                begin
                    if (count_reg != '0)
                    begin
                        rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                        if (rd_data_reg[DURATION_BITS-1:0] == '0)
                        begin
                            led_next = 1'b1;
                        end
                        else
                        begin
                            led_next  = rd_data_reg[DURATION_BITS];
                            time_next = rd_data_reg[DURATION_BITS-1:0];
                        end
                    end
                    else
                    begin
                        // Nothing queued: the LED is lit.
                        led_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
            time_reg   <= '0;
            led_reg    <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
            time_reg   <= time_next;
            led_reg    <= led_next;
        end
    end

    // The reported level keeps the low six bits of the fill count.
    assign level_wide = {{LEVEL_W{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            led_on_reg      <= led_next;
            push_status_reg <= drop;
            queue_level_reg <= level_wide[LEVEL_W-1:0];
            timer_busy_reg  <= (time_next != '0);
        end
    end

    assign led_on      = led_on_reg;
    assign push_status = push_status_reg;
    assign queue_level = queue_level_reg;
    assign timer_busy  = timer_busy_reg;

endmodule

// ===== rtl/led_pattern_sequencer_core.sv =====
// ============================================================================
// LED pattern sequencer core
// Queues LED events and plays them out one timer tick at a time.
// ============================================================================
// Each item steps through the controller's capture, event read and commit
// states around the registered read of the event memory; its result is
// registered at commit, which waits while a held result is stalled, and no new item is taken before commit.
// A new item may be taken while the previous result still waits.
// Reset clears the controller, queue indices, fill count, timer and LED level;
// the event memory is not initialised.
module led_pattern_sequencer_core
    import lps_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                func,
    input  logic                led_state,
    input  logic [DUR_IN_W-1:0] duration,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                led_on,
    output logic                push_status,
    output logic [LEVEL_W-1:0]  queue_level,
    output logic                timer_busy
);

    lps_cmd_t    cmd;
    lps_status_t status;

    // Controller.
    lps_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath.
    lps_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .led_state   (led_state),
        .duration    (duration),
        .led_on      (led_on),
        .push_status (push_status),
        .queue_level (queue_level),
        .timer_busy  (timer_busy)
    );

    // An item transfer is followed by the input stall, as the controller moves on to its read state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input taken on two consecutive cycles");

    // For a queue depth of at most 63, the reported level never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((QUEUE_DEPTH > 63) || (queue_level <= QUEUE_DEPTH)))
        else $error("queue level above depth");

    // A dropped push is only reported with a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && push_status) |-> (queue_level == LEVEL_W'(QUEUE_DEPTH)))
        else $error("push dropped while queue not full");

endmodule
